// File: rtl/slpl_pkg.sv
// Shared types and constants of the slab point location histogram block.
package slpl_pkg;

    localparam int MAX_PARTS_DEF  = 4096;
    localparam int MAX_POINTS_DEF = 4096;
    localparam int COORD_BITS_DEF = 20;
    localparam int OUT_BITS       = 13;
    localparam int CFG_IDX_BITS   = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TOP_Y    = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOTTOM_Y = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_LOCATE = 2'd2,
        OP_REPORT = 2'd3
    } t_op;

endpackage

// File: rtl/slab_point_location_histogram.sv
// Top level of the slab point location histogram block.
//
//  channel   signals                                   direction  transfer
//  command   start, busy, i_op, i_coord_a, i_coord_b   in         start && !busy
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,    in         i_cfg_valid && o_cfg_ready
//            i_cfg_data
//  result    o_valid, o_count_value, o_bins_with_count out        o_valid, one cycle
//            o_found, o_overflow
//
// Clear and reset run a sweep over the bin and histogram RAMs. Load walks the segment RAM to
// find the insertion point, then shifts the later segments and bins up by one entry.
// Locate: at most ceil(log2(n+1)) search probes, each a segment read, a cross product multiply
// and a compare, then the count and histogram update. Report scans the histogram counts in turn.
// A two-entry queue takes items while the back end works; busy rises when it is full.
// The receiver cannot stall: each result is shown for exactly one cycle.
module slab_point_location_histogram #(
    parameter int MAX_PARTS  = slpl_pkg::MAX_PARTS_DEF,
    parameter int MAX_POINTS = slpl_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = slpl_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_op,
    input  logic signed [COORD_BITS-1:0]          i_coord_a,
    input  logic signed [COORD_BITS-1:0]          i_coord_b,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [slpl_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic signed [COORD_BITS-1:0]          i_cfg_data,
    output logic                                  o_valid,
    output logic [slpl_pkg::OUT_BITS-1:0]         o_count_value,
    output logic [slpl_pkg::OUT_BITS-1:0]         o_bins_with_count,
    output logic                                  o_found,
    output logic                                  o_overflow
);

    logic signed [COORD_BITS-1:0] r_top_y;
    logic signed [COORD_BITS-1:0] r_bottom_y;
    logic                         q_valid;
    logic                         q_pop;
    slpl_pkg::t_op                q_op;
    logic signed [COORD_BITS-1:0] q_a;
    logic signed [COORD_BITS-1:0] q_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_y    <= '0;
            r_bottom_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                slpl_pkg::CFG_TOP_Y:    r_top_y    <= i_cfg_data;
                slpl_pkg::CFG_BOTTOM_Y: r_bottom_y <= i_cfg_data;
                default:                r_top_y    <= r_top_y;
            endcase
        end
    end

    slpl_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_coord_a(i_coord_a), .i_coord_b(i_coord_b),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_op(q_op), .o_q_a(q_a), .o_q_b(q_b)
    );

    slpl_back #(
        .MAX_PARTS(MAX_PARTS), .MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_op(q_op), .i_q_a(q_a), .i_q_b(q_b),
        .i_top_y(r_top_y), .i_bottom_y(r_bottom_y),
        .o_valid(o_valid), .o_count_value(o_count_value),
        .o_bins_with_count(o_bins_with_count), .o_found(o_found), .o_overflow(o_overflow)
    );

endmodule

// File: rtl/slpl_ram.sv
// Generic single write port, single read port RAM with registered read data.
module slpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/slpl_front.sv
// Command intake: decodes items and holds them in a two-entry queue.
module slpl_front #(
    parameter int COORD_BITS = slpl_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_op,
    input  logic signed [COORD_BITS-1:0] i_coord_a,
    input  logic signed [COORD_BITS-1:0] i_coord_b,
    output logic                         o_q_valid,
    input  logic                         i_q_pop,
    output slpl_pkg::t_op                o_q_op,
    output logic signed [COORD_BITS-1:0] o_q_a,
    output logic signed [COORD_BITS-1:0] o_q_b
);

    slpl_pkg::t_op               r_op [2];
    logic signed [COORD_BITS-1:0] r_a [2];
    logic signed [COORD_BITS-1:0] r_b [2];
    logic                        r_wp;
    logic                        r_rp;
    logic [1:0]                  r_cnt;
    logic                        push;
    logic                        pop;

    assign busy      = (r_cnt == 2'd2);
    assign push      = start && !busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_op    = r_op[r_rp];
    assign o_q_a     = r_a[r_rp];
    assign o_q_b     = r_b[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wp] <= slpl_pkg::t_op'(i_op);
            r_a[r_wp]  <= i_coord_a;
            r_b[r_wp]  <= i_coord_b;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/slpl_back.sv
// Command execution: segment store, binary search locate, counts, histogram and report scan.
module slpl_back #(
    parameter int MAX_PARTS  = slpl_pkg::MAX_PARTS_DEF,
    parameter int MAX_POINTS = slpl_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = slpl_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    output logic                              o_q_pop,
    input  slpl_pkg::t_op                     i_q_op,
    input  logic signed [COORD_BITS-1:0]      i_q_a,
    input  logic signed [COORD_BITS-1:0]      i_q_b,
    input  logic signed [COORD_BITS-1:0]      i_top_y,
    input  logic signed [COORD_BITS-1:0]      i_bottom_y,
    output logic                              o_valid,
    output logic [slpl_pkg::OUT_BITS-1:0]     o_count_value,
    output logic [slpl_pkg::OUT_BITS-1:0]     o_bins_with_count,
    output logic                              o_found,
    output logic                              o_overflow
);

    localparam int PW    = $clog2(MAX_PARTS + 1);
    localparam int PA    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int LW    = $clog2(MAX_PARTS + 2);
    localparam int HW    = $clog2(MAX_POINTS + 1);
    localparam int IW    = $clog2(MAX_POINTS + 2);
    localparam int HDW   = $clog2(MAX_PARTS + 2);
    localparam int MW    = (PW > HW) ? PW : HW;
    localparam int SWEEP = ((MAX_PARTS > MAX_POINTS) ? MAX_PARTS : MAX_POINTS) + 1;
    localparam int DW    = COORD_BITS + 1;
    localparam int XW    = 2 * DW;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LD_RD, S_LD_CMP, S_SH_RD, S_SH_WR,
        S_LC_RD, S_LC_MUL, S_LC_CMP, S_BN_RD, S_BN_WAIT, S_HD, S_HI,
        S_RP_RD, S_RP_CHK
    } t_state;

    t_state                  r_state, n_state;
    logic signed [COORD_BITS-1:0] r_a, n_a, r_b, n_b;
    logic [PW-1:0]           r_n, n_n, r_pos, n_pos, r_j, n_j;
    logic [LW-1:0]           r_l, n_l, r_r, n_r, r_mid, n_mid;
    logic signed [XW-1:0]    r_lhs, n_lhs, r_rhs, n_rhs;
    logic [HW-1:0]           r_points, n_points, r_cursor, n_cursor, r_c, n_c;
    logic [IW-1:0]           r_i, n_i;
    logic [MW-1:0]           r_cnt, n_cnt;
    logic                    r_ovf, n_ovf;
    logic                    r_valid, n_valid, r_found, n_found, r_oovf, n_oovf;
    logic [slpl_pkg::OUT_BITS-1:0] r_count, n_count, r_bins, n_bins;

    logic                    part_we;
    logic [PA-1:0]           part_waddr, part_raddr;
    logic [COORD_BITS-1:0]   top_wdata, bot_wdata, rd_top, rd_bot;
    logic                    bin_we;
    logic [PW-1:0]           bin_waddr, bin_raddr;
    logic [HW-1:0]           bin_wdata, rd_bin;
    logic                    hist_we;
    logic [HW-1:0]           hist_waddr, hist_raddr;
    logic [HDW-1:0]          hist_wdata, rd_hist;

    logic [LW:0]             lr_sum;
    logic [LW-1:0]           mid_c;
    logic signed [DW-1:0]    dx, dy, dyb, dxb;
    logic [PW-1:0]           j_m1, j_p1, pos_p1;

    slpl_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PARTS)) u_top_ram (
        .i_clk(i_clk), .i_we(part_we), .i_waddr(part_waddr), .i_wdata(top_wdata),
        .i_raddr(part_raddr), .o_rdata(rd_top)
    );
    slpl_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PARTS)) u_bot_ram (
        .i_clk(i_clk), .i_we(part_we), .i_waddr(part_waddr), .i_wdata(bot_wdata),
        .i_raddr(part_raddr), .o_rdata(rd_bot)
    );
    slpl_ram #(.WIDTH(HW), .DEPTH(MAX_PARTS + 1)) u_bin_ram (
        .i_clk(i_clk), .i_we(bin_we), .i_waddr(bin_waddr), .i_wdata(bin_wdata),
        .i_raddr(bin_raddr), .o_rdata(rd_bin)
    );
    slpl_ram #(.WIDTH(HDW), .DEPTH(MAX_POINTS + 1)) u_hist_ram (
        .i_clk(i_clk), .i_we(hist_we), .i_waddr(hist_waddr), .i_wdata(hist_wdata),
        .i_raddr(hist_raddr), .o_rdata(rd_hist)
    );

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    assign lr_sum = {1'b0, r_l} + {1'b0, r_r};
    assign mid_c  = lr_sum[LW:1];
    assign j_m1   = r_j - PW'(1);
    assign j_p1   = r_j + PW'(1);
    assign pos_p1 = r_pos + PW'(1);
    assign dx     = $signed({r_a[COORD_BITS-1], r_a}) - $signed({rd_top[COORD_BITS-1], rd_top});
    assign dy     = $signed({r_b[COORD_BITS-1], r_b})
                  - $signed({i_top_y[COORD_BITS-1], i_top_y});
    assign dyb    = $signed({i_bottom_y[COORD_BITS-1], i_bottom_y})
                  - $signed({i_top_y[COORD_BITS-1], i_top_y});
    assign dxb    = $signed({rd_bot[COORD_BITS-1], rd_bot})
                  - $signed({rd_top[COORD_BITS-1], rd_top});

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_n      = r_n;
        n_pos    = r_pos;
        n_j      = r_j;
        n_l      = r_l;
        n_r      = r_r;
        n_mid    = r_mid;
        n_lhs    = r_lhs;
        n_rhs    = r_rhs;
        n_points = r_points;
        n_cursor = r_cursor;
        n_c      = r_c;
        n_i      = r_i;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_valid  = 1'b0;
        n_found  = r_found;
        n_oovf   = r_oovf;
        n_count  = r_count;
        n_bins   = r_bins;

        part_we    = 1'b0;
        part_waddr = '0;
        part_raddr = '0;
        top_wdata  = rd_top;
        bot_wdata  = rd_bot;
        bin_we     = 1'b0;
        bin_waddr  = '0;
        bin_wdata  = '0;
        bin_raddr  = '0;
        hist_we    = 1'b0;
        hist_waddr = '0;
        hist_wdata = '0;
        hist_raddr = '0;

        case (r_state)
            S_CLR: begin
                bin_we     = (r_cnt <= MW'(MAX_PARTS));
                bin_waddr  = r_cnt[PW-1:0];
                hist_we    = (r_cnt <= MW'(MAX_POINTS));
                hist_waddr = r_cnt[HW-1:0];
                n_cnt      = r_cnt + MW'(1);
                if (r_cnt == MW'(SWEEP - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_a = i_q_a;
                    n_b = i_q_b;
                    case (i_q_op)
                        slpl_pkg::OP_CLEAR: begin
                            n_cnt    = '0;
                            n_n      = '0;
                            n_points = '0;
                            n_cursor = '0;
                            n_ovf    = 1'b0;
                            n_state  = S_CLR;
                        end
                        slpl_pkg::OP_LOAD: begin
                            if (r_n == PW'(MAX_PARTS)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_pos   = '0;
                                n_state = S_LD_RD;
                            end
                        end
                        slpl_pkg::OP_LOCATE: begin
                            if (r_points == HW'(MAX_POINTS)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_l     = '0;
                                n_r     = LW'(r_n) + LW'(1);
                                n_state = S_LC_RD;
                            end
                        end
                        default: begin
                            n_i     = IW'(r_cursor) + IW'(1);
                            n_state = S_RP_RD;
                        end
                    endcase
                end
            end
            S_LD_RD: begin
                if (r_pos < r_n) begin
                    part_raddr = r_pos[PA-1:0];
                    n_state    = S_LD_CMP;
                end else begin
                    n_j     = r_n;
                    n_state = S_SH_RD;
                end
            end
            S_LD_CMP: begin
                if ($signed(rd_top) <= r_a) begin
                    n_pos   = pos_p1;
                    n_state = S_LD_RD;
                end else begin
                    n_j     = r_n;
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (r_j > r_pos) begin
                    part_raddr = j_m1[PA-1:0];
                    bin_raddr  = r_j;
                    n_state    = S_SH_WR;
                end else begin
                    part_we    = 1'b1;
                    part_waddr = r_pos[PA-1:0];
                    top_wdata  = r_a;
                    bot_wdata  = r_b;
                    bin_we     = 1'b1;
                    bin_waddr  = pos_p1;
                    n_n        = r_n + PW'(1);
                    n_state    = S_IDLE;
                end
            end
            S_SH_WR: begin
                part_we    = 1'b1;
                part_waddr = r_j[PA-1:0];
                bin_we     = 1'b1;
                bin_waddr  = j_p1;
                bin_wdata  = rd_bin;
                n_j        = j_m1;
                n_state    = S_SH_RD;
            end
            S_LC_RD: begin
                if ((r_r - r_l) > LW'(1)) begin
                    n_mid      = mid_c;
                    part_raddr = PA'(mid_c - LW'(1));
                    n_state    = S_LC_MUL;
                end else begin
                    n_state = S_BN_RD;
                end
            end
            S_LC_MUL: begin
                n_lhs   = dx * dyb;
                n_rhs   = dy * dxb;
                n_state = S_LC_CMP;
            end
            S_LC_CMP: begin
                if (r_lhs < r_rhs) begin
                    n_l = r_mid;
                end else begin
                    n_r = r_mid;
                end
                n_state = S_LC_RD;
            end
            S_BN_RD: begin
                bin_raddr = r_l[PW-1:0];
                n_state   = S_BN_WAIT;
            end
            S_BN_WAIT: begin
                n_points = r_points + HW'(1);
                n_c      = rd_bin;
                if (rd_bin < HW'(MAX_POINTS)) begin
                    bin_we    = 1'b1;
                    bin_waddr = r_l[PW-1:0];
                    bin_wdata = rd_bin + HW'(1);
                    if (rd_bin != '0) begin
                        hist_raddr = rd_bin;
                        n_state    = S_HD;
                    end else begin
                        hist_raddr = rd_bin + HW'(1);
                        n_state    = S_HI;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HD: begin
                hist_we    = 1'b1;
                hist_waddr = r_c;
                hist_wdata = rd_hist - HDW'(1);
                hist_raddr = r_c + HW'(1);
                n_state    = S_HI;
            end
            S_HI: begin
                hist_we    = 1'b1;
                hist_waddr = r_c + HW'(1);
                hist_wdata = rd_hist + HDW'(1);
                n_state    = S_IDLE;
            end
            S_RP_RD: begin
                if (r_i <= IW'(r_points)) begin
                    hist_raddr = r_i[HW-1:0];
                    n_state    = S_RP_CHK;
                end else begin
                    n_valid = 1'b1;
                    n_found = 1'b0;
                    n_count = '0;
                    n_bins  = '0;
                    n_oovf  = r_ovf;
                    n_state = S_IDLE;
                end
            end
            S_RP_CHK: begin
                if (rd_hist != '0) begin
                    n_valid  = 1'b1;
                    n_found  = 1'b1;
                    n_count  = slpl_pkg::OUT_BITS'(r_i);
                    n_bins   = slpl_pkg::OUT_BITS'(rd_hist);
                    n_oovf   = r_ovf;
                    n_cursor = r_i[HW-1:0];
                    n_state  = S_IDLE;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_RP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_pos   <= n_pos;
        r_j     <= n_j;
        r_l     <= n_l;
        r_r     <= n_r;
        r_mid   <= n_mid;
        r_lhs   <= n_lhs;
        r_rhs   <= n_rhs;
        r_c     <= n_c;
        r_i     <= n_i;
        r_found <= n_found;
        r_oovf  <= n_oovf;
        r_count <= n_count;
        r_bins  <= n_bins;
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_n      <= '0;
            r_points <= '0;
            r_cursor <= '0;
            r_ovf    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_n      <= n_n;
            r_points <= n_points;
            r_cursor <= n_cursor;
            r_ovf    <= n_ovf;
            r_valid  <= n_valid;
        end
    end

    assign o_valid           = r_valid;
    assign o_count_value     = r_count;
    assign o_bins_with_count = r_bins;
    assign o_found           = r_found;
    assign o_overflow        = r_oovf;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_q_pop) else $error("item taken during clearing pass");
    a_parts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= PW'(MAX_PARTS)) else $error("segment count beyond capacity");
    a_points_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_points <= HW'(MAX_POINTS)) else $error("point count beyond capacity");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LC_RD) |-> (r_l < r_r)) else $error("search bounds crossed");
    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_found) |-> (r_count == '0 && r_bins == '0))
        else $error("empty report carries data");

endmodule

// File: tb/sv/tb_slab_point_location_histogram.sv
// Self-checking testbench of the slab point location histogram block.
`timescale 1ns / 1ps

module tb_slab_point_location_histogram;

    localparam int NPARTS  = 4096;
    localparam int NPOINTS = 4096;
    localparam int CW      = 20;
    localparam int SETTLE  = 9000;
    localparam int STALL_LIMIT = 60000;

    typedef struct {
        logic [slpl_pkg::OUT_BITS-1:0] count_value;
        logic [slpl_pkg::OUT_BITS-1:0] bins_with_count;
        logic                          found;
        logic                          overflow;
    } t_report;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_op;
    logic signed [CW-1:0] i_coord_a;
    logic signed [CW-1:0] i_coord_b;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [slpl_pkg::CFG_IDX_BITS-1:0] i_cfg_index;
    logic signed [CW-1:0] i_cfg_data;
    logic                 o_valid;
    logic [slpl_pkg::OUT_BITS-1:0] o_count_value;
    logic [slpl_pkg::OUT_BITS-1:0] o_bins_with_count;
    logic                 o_found;
    logic                 o_overflow;

    slab_point_location_histogram dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_coord_a         (i_coord_a),
        .i_coord_b         (i_coord_b),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_count_value     (o_count_value),
        .o_bins_with_count (o_bins_with_count),
        .o_found           (o_found),
        .o_overflow        (o_overflow)
    );

    // predictor state
    int seg_top [NPARTS];
    int seg_bot [NPARTS];
    int bin_hits [NPARTS+1];
    int hits_hist [NPOINTS+1];
    int seg_total;
    int point_total;
    int scan_cursor;
    bit drop_seen;
    logic signed [CW-1:0] edge_top_y;
    logic signed [CW-1:0] edge_bot_y;

    t_report pending_reports[$];
    int  mismatches;
    int  reports_seen;
    int  found_seen;
    int  items_sent;
    int  idle_cycles;
    bit  gaps_on;
    bit  cmd_xfer;
    bit  cfg_xfer;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic clear_model();
        seg_total   = 0;
        point_total = 0;
        scan_cursor = 0;
        drop_seen   = 1'b0;
        for (int i = 0; i <= NPARTS; i++) bin_hits[i] = 0;
        for (int i = 0; i <= NPOINTS; i++) hits_hist[i] = 0;
        hits_hist[0] = 1;
    endtask

    function automatic bit right_of_seg(int idx, int px, int py);
        longint ty;
        longint by;
        longint lhs;
        longint rhs;
        ty  = longint'(edge_top_y);
        by  = longint'(edge_bot_y);
        lhs = (longint'(px) - seg_top[idx]) * (by - ty);
        rhs = (longint'(py) - ty) * (longint'(seg_bot[idx]) - seg_top[idx]);
        return lhs < rhs;
    endfunction

    task automatic predict_item(slpl_pkg::t_op op, int a, int b);
        int pos;
        int lo;
        int hi;
        int mid;
        int c;
        t_report r;
        case (op)
            slpl_pkg::OP_CLEAR: clear_model();
            slpl_pkg::OP_LOAD: begin
                if (seg_total >= NPARTS) begin
                    drop_seen = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < seg_total && seg_top[pos] <= a) pos++;
                    for (int k = seg_total; k > pos; k--) begin
                        seg_top[k] = seg_top[k-1];
                        seg_bot[k] = seg_bot[k-1];
                    end
                    seg_top[pos] = a;
                    seg_bot[pos] = b;
                    for (int k = seg_total + 1; k > pos + 1; k--) bin_hits[k] = bin_hits[k-1];
                    bin_hits[pos+1] = 0;
                    hits_hist[0]++;
                    seg_total++;
                end
            end
            slpl_pkg::OP_LOCATE: begin
                if (point_total >= NPOINTS) begin
                    drop_seen = 1'b1;
                end else begin
                    lo = 0;
                    hi = seg_total + 1;
                    while (hi - lo > 1) begin
                        mid = (lo + hi) / 2;
                        if (right_of_seg(mid - 1, a, b)) lo = mid;
                        else hi = mid;
                    end
                    c = bin_hits[lo];
                    if (c < NPOINTS) begin
                        hits_hist[c]--;
                        hits_hist[c+1]++;
                        bin_hits[lo] = c + 1;
                    end
                    point_total++;
                end
            end
            default: begin
                r.count_value     = '0;
                r.bins_with_count = '0;
                r.found           = 1'b0;
                r.overflow        = drop_seen;
                for (int i = scan_cursor + 1; i <= point_total && i <= NPOINTS; i++) begin
                    if (hits_hist[i] != 0) begin
                        r.count_value     = i[slpl_pkg::OUT_BITS-1:0];
                        r.bins_with_count = hits_hist[i][slpl_pkg::OUT_BITS-1:0];
                        r.found           = 1'b1;
                        scan_cursor       = i;
                        break;
                    end
                end
                pending_reports.push_back(r);
            end
        endcase
    endtask

    task automatic send_item(slpl_pkg::t_op op, int a, int b);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_op      <= op;
        i_coord_a <= a[CW-1:0];
        i_coord_b <= b[CW-1:0];
        do @(posedge i_clk); while (busy);
        predict_item(op, int'(signed'(a[CW-1:0])), int'(signed'(b[CW-1:0])));
        items_sent++;
    endtask

    task automatic wait_reports();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [slpl_pkg::CFG_IDX_BITS-1:0] idx, int value);
        wait_reports();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CW-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == slpl_pkg::CFG_TOP_Y) edge_top_y = value[CW-1:0];
        else edge_bot_y = value[CW-1:0];
    endtask

    function automatic int rand_coord();
        return int'(signed'(CW'($urandom)));
    endfunction

    function automatic int rand_between(int lo, int hi);
        if (lo > hi) return hi + int'($urandom_range(0, lo - hi));
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic test_directed();
        gaps_on = 1'b1;
        send_item(slpl_pkg::OP_REPORT, 0, 0);
        send_item(slpl_pkg::OP_LOCATE, 524287, -524288);
        send_item(slpl_pkg::OP_LOAD, -524288, 524287);
        send_item(slpl_pkg::OP_LOAD, 524287, -524288);
        send_item(slpl_pkg::OP_LOAD, 0, 0);
        send_item(slpl_pkg::OP_LOAD, 0, 100);
        send_item(slpl_pkg::OP_LOCATE, -524288, -524288);
        send_item(slpl_pkg::OP_LOCATE, 524287, 524287);
        send_item(slpl_pkg::OP_LOCATE, 0, 0);
        send_item(slpl_pkg::OP_LOCATE, 0, 0);
        send_item(slpl_pkg::OP_LOAD, 1, -1);
        send_item(slpl_pkg::OP_LOCATE, -1, 1);
        send_item(slpl_pkg::OP_REPORT, 0, 0);
        send_item(slpl_pkg::OP_REPORT, 0, 0);
        send_item(slpl_pkg::OP_REPORT, 0, 0);
        wait_reports();
        send_item(slpl_pkg::OP_CLEAR, 0, 0);
        send_item(slpl_pkg::OP_REPORT, 0, 0);
        cfg_write(slpl_pkg::CFG_TOP_Y, 524287);
        cfg_write(slpl_pkg::CFG_BOTTOM_Y, -524288);
        send_item(slpl_pkg::OP_LOAD, -1000, 1000);
        send_item(slpl_pkg::OP_LOCATE, 0, 0);
        send_item(slpl_pkg::OP_LOCATE, 0, 524287);
        send_item(slpl_pkg::OP_LOCATE, 0, -524288);
        send_item(slpl_pkg::OP_REPORT, 0, 0);
        send_item(slpl_pkg::OP_REPORT, 0, 0);
    endtask

    task automatic test_dense_bins();
        gaps_on = 1'b0;
        send_item(slpl_pkg::OP_CLEAR, 0, 0);
        send_item(slpl_pkg::OP_LOAD, -300000, 300000);
        send_item(slpl_pkg::OP_LOAD, 300000, -300000);
        for (int i = 0; i < 300; i++) begin
            send_item(slpl_pkg::OP_LOCATE, rand_coord(), rand_coord());
        end
        for (int i = 0; i < 4; i++) send_item(slpl_pkg::OP_REPORT, 0, 0);
        send_item(slpl_pkg::OP_LOAD, 5, 5);
        send_item(slpl_pkg::OP_REPORT, 0, 0);
        send_item(slpl_pkg::OP_CLEAR, 0, 0);
        send_item(slpl_pkg::OP_REPORT, 0, 0);
    endtask

    task automatic random_phase(int n_items, bit allow_gaps);
        int n_seg;
        int shift;
        int lo_y;
        int hi_y;
        int t;
        int roll;
        gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
        n_seg = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
        shift = rand_between(-100000, 100000);
        lo_y  = int'(edge_bot_y);
        hi_y  = int'(edge_top_y);
        send_item(slpl_pkg::OP_CLEAR, rand_coord(), rand_coord());
        for (int i = 0; i < n_seg; i++) begin
            t = rand_between(-200000, 200000);
            if (i > 0 && $urandom_range(0, 5) == 0) t = seg_top[$urandom_range(0, seg_total - 1)];
            send_item(slpl_pkg::OP_LOAD, t, t + shift);
        end
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                send_item(slpl_pkg::OP_LOCATE, rand_between(-320000, 320000),
                    rand_between(lo_y, hi_y));
            else if (roll < 80)
                send_item(slpl_pkg::OP_REPORT, rand_coord(), rand_coord());
            else if (roll < 88) begin
                t = rand_between(-200000, 200000);
                send_item(slpl_pkg::OP_LOAD, t, t + shift);
            end else if (roll < 97)
                send_item(slpl_pkg::t_op'($urandom_range(1, 3)), rand_coord(), rand_coord());
            else
                send_item(slpl_pkg::OP_CLEAR, rand_coord(), rand_coord());
        end
        for (int i = 0; i < 6; i++) send_item(slpl_pkg::OP_REPORT, 0, 0);
    endtask

    task automatic test_random();
        int ty;
        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin
                    cfg_write(slpl_pkg::CFG_TOP_Y, -524288);
                    cfg_write(slpl_pkg::CFG_BOTTOM_Y, 524287);
                end
                1: begin
                    ty = rand_coord();
                    cfg_write(slpl_pkg::CFG_TOP_Y, ty);
                    cfg_write(slpl_pkg::CFG_BOTTOM_Y, ty);
                end
                default: begin
                    cfg_write(slpl_pkg::CFG_TOP_Y, rand_coord());
                    cfg_write(slpl_pkg::CFG_BOTTOM_Y, rand_coord());
                end
            endcase
            random_phase(60, 1'b1);
        end
        random_phase(40, 1'b0);
    endtask

    always @(posedge i_clk) begin
        t_report want;
        cmd_xfer = start && !busy;
        cfg_xfer = i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_valid) begin
                reports_seen++;
                if (o_found) found_seen++;
                if (pending_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
                end else begin
                    want = pending_reports.pop_front();
                    if (o_count_value !== want.count_value
                            || o_bins_with_count !== want.bins_with_count
                            || o_found !== want.found || o_overflow !== want.overflow) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp cnt=%0d bins=%0d f=%0b o=%0b",
                                " got cnt=%0d bins=%0d f=%0b o=%0b"},
                                want.count_value, want.bins_with_count, want.found,
                                want.overflow, o_count_value, o_bins_with_count,
                                o_found, o_overflow);
                    end
                end
            end
            if (o_valid || cmd_xfer || cfg_xfer) idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = slpl_pkg::OP_CLEAR;
        i_coord_a   = '0;
        i_coord_b   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = slpl_pkg::CFG_TOP_Y;
        i_cfg_data  = '0;
        mismatches   = 0;
        reports_seen = 0;
        found_seen   = 0;
        items_sent   = 0;
        gaps_on      = 1'b0;
        edge_top_y   = '0;
        edge_bot_y   = '0;
        clear_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_dense_bins();
        test_random();
        wait_reports();
        repeat (SETTLE) @(posedge i_clk);
        if (pending_reports.size() != 0) mismatches++;
        $display("covered %0d commands, %0d reports (%0d with an entry), several edge settings",
            items_sent, reports_seen, found_seen);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/slpl_pkg.sv
rtl/slpl_ram.sv
rtl/slpl_front.sv
rtl/slpl_back.sv
rtl/slab_point_location_histogram.sv
tb/sv/tb_slab_point_location_histogram.sv
